/* src/assert_macros.svh */
// Assertion macros shared by the hash map RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert an implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/chm_pkg.sv */
// Package for the chained hash map: sizes, codes and types.
// No dependencies.
package chm_pkg;
  localparam int unsigned NumBuckets = 4093;
  localparam int unsigned Capacity   = 2048;
  localparam int unsigned BktW       = $clog2(NumBuckets);
  localparam int unsigned IdW        = $clog2(Capacity + 1);
  localparam int unsigned EntW       = $clog2(Capacity);
  localparam int unsigned ValW       = 24;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned EntryW     = 2 * KeyW + ValW + IdW;
  localparam int unsigned HashW      = BktW + 1;

  // Weight of one BktW-bit chunk step, 2^BktW mod NumBuckets.
  localparam int unsigned Fold       = (1 << BktW) % NumBuckets;

  localparam logic [1:0] StFound    = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StInserted = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  localparam logic ActSet = 1'b0;
  localparam logic ActGet = 1'b1;

  localparam logic [BktW-1:0] Mult60 =
    BktW'(((64'd1 << 60) % 64'(NumBuckets)));

  typedef struct packed {
    logic [KeyW-1:0] key_high;
    logic [KeyW-1:0] key_low;
    logic [ValW-1:0] value;
    logic [IdW-1:0]  next;
  } entry_t;

  typedef struct packed {
    logic            start;
    logic [KeyW-1:0] key_high;
    logic [KeyW-1:0] key_low;
  } hash_req_t;

  typedef struct packed {
    logic            done;
    logic [BktW-1:0] bucket;
  } hash_rsp_t;
endpackage

/* src/chm_if.sv */
// Valid/ready channel interfaces for the chained hash map.
// Depends on chm_pkg.
interface chm_req_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [chm_pkg::KeyW-1:0] key_high;
  logic [chm_pkg::KeyW-1:0] key_low;
  logic [chm_pkg::ValW-1:0] value_in;
  modport source (output valid, action, key_high, key_low, value_in, input ready);
  modport sink (input valid, action, key_high, key_low, value_in, output ready);
endinterface

interface chm_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [chm_pkg::ValW-1:0] value_out;
  modport source (output valid, status, value_out, input ready);
  modport sink (input valid, status, value_out, output ready);
endinterface

/* src/chained_hash_map_128bit_key.sv */
// Chained hash map top level: request/response channels, bucket and entry RAMs.
// Depends on chm_pkg, chm_if, chm_ram, chm_hash and assert_macros.svh.
// One word at a time. After reset a clearing pass zeroes the 4093 bucket
// heads, one per cycle, and no word is accepted until that pass ends. Each
// word then passes the hash pipeline (S_HASH), reads its bucket head
// (S_HEAD), spends S_RDENT and S_CMP on each chain entry visited (entry RAM
// read, then compare), a final S_RDENT at the chain end, S_WRITE to write,
// S_LINK to link a new entry behind an existing tail, and S_RESP in the
// output register until taken; ready returns the cycle after.
`include "assert_macros.svh"

module chained_hash_map_128bit_key (
  input  logic          clk_i,
  input  logic          rst_ni,
  chm_req_if.sink       req,
  chm_rsp_if.source     rsp
);
  typedef enum logic [8:0] {
    S_CLEAR = 9'b0_0000_0001,
    S_IDLE  = 9'b0_0000_0010,
    S_HASH  = 9'b0_0000_0100,
    S_HEAD  = 9'b0_0000_1000,
    S_RDENT = 9'b0_0001_0000,
    S_CMP   = 9'b0_0010_0000,
    S_WRITE = 9'b0_0100_0000,
    S_LINK  = 9'b0_1000_0000,
    S_RESP  = 9'b1_0000_0000
  } state_e;

  state_e                    state_q, state_d;
  logic [chm_pkg::BktW-1:0]  clr_q, clr_d;
  logic                      act_q;
  logic [chm_pkg::KeyW-1:0]  kh_q, kl_q;
  logic [chm_pkg::ValW-1:0]  val_q;
  logic [chm_pkg::BktW-1:0]  bkt_q, bkt_d;
  logic [chm_pkg::IdW-1:0]   id_q, id_d, tail_q, tail_d, used_q, used_d;
  logic [1:0]                st_q, st_d;
  logic [chm_pkg::ValW-1:0]  vout_q, vout_d;
  logic                      found_q, found_d;
  chm_pkg::entry_t           ent_q, ent_d;

  logic                      hd_we, en_we;
  logic [chm_pkg::BktW-1:0]  hd_waddr, hd_raddr;
  logic [chm_pkg::IdW-1:0]   hd_wdata, hd_rdata;
  logic [chm_pkg::EntW-1:0]  en_waddr, en_raddr;
  chm_pkg::entry_t           en_wdata, en_rdata;
  chm_pkg::hash_req_t        hreq;
  chm_pkg::hash_rsp_t        hrsp;
  logic                      accept;

  chm_ram #(.Width(chm_pkg::IdW), .Depth(chm_pkg::NumBuckets)) u_heads (
    .clk_i, .we_i(hd_we), .waddr_i(hd_waddr), .wdata_i(hd_wdata),
    .raddr_i(hd_raddr), .rdata_o(hd_rdata)
  );

  chm_ram #(.Width(chm_pkg::EntryW), .Depth(chm_pkg::Capacity)) u_entries (
    .clk_i, .we_i(en_we), .waddr_i(en_waddr), .wdata_i(en_wdata),
    .raddr_i(en_raddr), .rdata_o(en_rdata)
  );

  chm_hash u_hash (.clk_i, .rst_ni, .req_i(hreq), .rsp_o(hrsp));

  assign req.ready     = (state_q == S_IDLE);
  assign accept        = req.valid && req.ready;
  assign rsp.valid     = (state_q == S_RESP);
  assign rsp.status    = st_q;
  assign rsp.value_out = vout_q;

  assign hreq.start    = accept;
  assign hreq.key_high = req.key_high;
  assign hreq.key_low  = req.key_low;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    bkt_d    = bkt_q;
    id_d     = id_q;
    tail_d   = tail_q;
    used_d   = used_q;
    st_d     = st_q;
    vout_d   = vout_q;
    found_d  = found_q;
    ent_d    = ent_q;
    hd_we    = 1'b0;
    hd_waddr = bkt_q;
    hd_wdata = '0;
    hd_raddr = bkt_q;
    en_we    = 1'b0;
    en_waddr = chm_pkg::EntW'(id_q - 1'b1);
    en_wdata = ent_q;
    en_raddr = chm_pkg::EntW'(id_q - 1'b1);
    case (state_q)
      S_CLEAR: begin
        hd_we    = 1'b1;
        hd_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == chm_pkg::BktW'(chm_pkg::NumBuckets - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (hrsp.done) begin
          bkt_d    = hrsp.bucket;
          hd_raddr = hrsp.bucket;
          tail_d   = '0;
          state_d  = S_HEAD;
        end
      end
      S_HEAD: begin
        id_d    = hd_rdata;
        state_d = S_RDENT;
      end
      S_RDENT: begin
        if (id_q == '0) begin
          found_d = 1'b0;
          state_d = S_WRITE;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        ent_d = en_rdata;
        if (en_rdata.key_high == kh_q && en_rdata.key_low == kl_q) begin
          found_d = 1'b1;
          state_d = S_WRITE;
        end else begin
          tail_d  = id_q;
          id_d    = en_rdata.next;
          state_d = S_RDENT;
        end
      end
      S_WRITE: begin
        vout_d  = '0;
        state_d = S_RESP;
        if (act_q == chm_pkg::ActGet) begin
          st_d = found_q ? chm_pkg::StFound : chm_pkg::StNotFound;
          if (found_q) begin
            vout_d = ent_q.value;
          end
        end else if (found_q) begin
          st_d     = chm_pkg::StFound;
          en_we    = 1'b1;
          en_wdata = ent_q;
          en_wdata.value = val_q;
        end else if (used_q == chm_pkg::IdW'(chm_pkg::Capacity)) begin
          st_d = chm_pkg::StFull;
        end else begin
          st_d              = chm_pkg::StInserted;
          en_we             = 1'b1;
          en_waddr          = chm_pkg::EntW'(used_q);
          en_wdata.key_high = kh_q;
          en_wdata.key_low  = kl_q;
          en_wdata.value    = val_q;
          en_wdata.next     = '0;
          used_d            = used_q + 1'b1;
          if (tail_q == '0) begin
            hd_we    = 1'b1;
            hd_waddr = bkt_q;
            hd_wdata = used_q + 1'b1;
          end else begin
            ent_d.next = used_q + 1'b1;
            state_d    = S_LINK;
          end
        end
      end
      S_LINK: begin
        en_we    = 1'b1;
        en_waddr = chm_pkg::EntW'(tail_q - 1'b1);
        en_wdata = ent_q;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (rsp.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= req.action;
      kh_q  <= req.key_high;
      kl_q  <= req.key_low;
      val_q <= req.value_in;
    end
    bkt_q   <= bkt_d;
    id_q    <= id_d;
    tail_q  <= tail_d;
    st_q    <= st_d;
    vout_q  <= vout_d;
    found_q <= found_d;
    ent_q   <= ent_d;
  end

  `ASSERT_IMPL(a_used_bound, clk_i, rst_ni, 1'b1,
    used_q <= chm_pkg::IdW'(chm_pkg::Capacity))
  `ASSERT_NEXT(a_accept_hash, clk_i, rst_ni, accept, state_q == S_HASH)
  `ASSERT_IMPL(a_no_ready_clear, clk_i, rst_ni, state_q == S_CLEAR, !req.ready)
endmodule

/* src/chm_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module chm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* src/chm_hash.sv */
// Bucket hash: ((kh mod N) * (2^60 mod N) + kl mod N) mod N, six-stage pipeline.
// Folds 12-bit chunks by their weights 2^12k mod N, then one multiply and fold.
// Depends on chm_pkg.
module chm_hash (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  chm_pkg::hash_req_t  req_i,
  output chm_pkg::hash_rsp_t  rsp_o
);
  localparam int unsigned B     = chm_pkg::BktW;
  localparam int unsigned FoldW = 19;
  localparam int unsigned ProdW = 2 * chm_pkg::BktW + 1;
  localparam int unsigned F1    = chm_pkg::Fold;
  localparam int unsigned F2    = F1 * F1;
  localparam int unsigned F3    = F2 * F1;
  localparam int unsigned F4    = F3 * F1;
  localparam int unsigned F5    = F4 * F1;
  localparam logic [chm_pkg::HashW-1:0] N = chm_pkg::HashW'(chm_pkg::NumBuckets);

  logic [5:0]                vld_q, vld_d;
  logic [chm_pkg::KeyW-1:0]  kh_q, kl_q;
  logic [FoldW-1:0]          fh_q, fl_q, fa_q;
  logic [B-1:0]              rh_q, rl_q, bkt_q;
  logic [ProdW-1:0]          acc_q;

  function automatic logic [FoldW-1:0] fold_word(logic [chm_pkg::KeyW-1:0] x);
    return FoldW'(x[B-1:0]) + FoldW'(x[2*B-1:B]) * FoldW'(F1)
         + FoldW'(x[3*B-1:2*B]) * FoldW'(F2) + FoldW'(x[4*B-1:3*B]) * FoldW'(F3)
         + FoldW'(x[5*B-1:4*B]) * FoldW'(F4)
         + FoldW'(x[chm_pkg::KeyW-1:5*B]) * FoldW'(F5);
  endfunction

  function automatic logic [B-1:0] reduce(logic [FoldW-1:0] x);
    logic [chm_pkg::HashW-1:0] t;
    t = chm_pkg::HashW'(x[B-1:0]) + chm_pkg::HashW'(x[FoldW-1:B]) * chm_pkg::HashW'(F1);
    return (t >= N) ? B'(t - N) : B'(t);
  endfunction

  always_comb begin
    vld_d = {vld_q[4:0], req_i.start};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      kh_q <= req_i.key_high;
      kl_q <= req_i.key_low;
    end
    fh_q  <= fold_word(kh_q);
    fl_q  <= fold_word(kl_q);
    rh_q  <= reduce(fh_q);
    rl_q  <= reduce(fl_q);
    acc_q <= ProdW'(rh_q) * ProdW'(chm_pkg::Mult60) + ProdW'(rl_q);
    fa_q  <= FoldW'(acc_q[B-1:0]) + FoldW'(acc_q[2*B-1:B]) * FoldW'(F1)
           + FoldW'(acc_q[ProdW-1]) * FoldW'(F2);
    bkt_q <= reduce(fa_q);
  end

  assign rsp_o.done   = vld_q[5];
  assign rsp_o.bucket = bkt_q;
endmodule

/* bench/chm_tb_pkg.sv */
// Scoreboard for the chained hash map bench: a predictor of the bucket
// chains and entry store, and a queue of expected responses. Depends on chm_pkg.
`timescale 1ns / 1ps
package chm_tb_pkg;

  typedef struct packed {
    logic [1:0]               status;
    logic [chm_pkg::ValW-1:0] value;
  } lookup_rsp_t;

  class hash_map_scoreboard;
    int unsigned bucket_head[chm_pkg::NumBuckets];
    logic [chm_pkg::KeyW-1:0] ent_key_high[chm_pkg::Capacity];
    logic [chm_pkg::KeyW-1:0] ent_key_low[chm_pkg::Capacity];
    logic [chm_pkg::ValW-1:0] ent_value[chm_pkg::Capacity];
    int unsigned ent_next[chm_pkg::Capacity];
    int unsigned used;
    lookup_rsp_t pending_rsp[$];
    int unsigned mismatches;

    function new();
      foreach (bucket_head[i]) bucket_head[i] = 0;
      used = 0;
      mismatches = 0;
    endfunction

    function int unsigned bucket_index(logic [chm_pkg::KeyW-1:0] kh,
                                       logic [chm_pkg::KeyW-1:0] kl);
      logic [127:0] h;
      h = 128'(kh % 64'(chm_pkg::NumBuckets))
          * 128'(((64'd1 << 60) % 64'(chm_pkg::NumBuckets)))
          + 128'(kl % 64'(chm_pkg::NumBuckets));
      return int'(h % 128'(chm_pkg::NumBuckets));
    endfunction

    function void note_request(logic act, logic [chm_pkg::KeyW-1:0] kh,
                               logic [chm_pkg::KeyW-1:0] kl,
                               logic [chm_pkg::ValW-1:0] v);
      int unsigned b, id, last, e;
      lookup_rsp_t r;
      b = bucket_index(kh, kl);
      id = bucket_head[b];
      last = 0;
      while (id != 0) begin
        if (ent_key_high[id-1] == kh && ent_key_low[id-1] == kl) break;
        last = id;
        id = ent_next[id-1];
      end
      r.value = '0;
      if (act == chm_pkg::ActGet) begin
        if (id != 0) begin
          r.status = chm_pkg::StFound;
          r.value = ent_value[id-1];
        end else begin
          r.status = chm_pkg::StNotFound;
        end
      end else if (id != 0) begin
        ent_value[id-1] = v;
        r.status = chm_pkg::StFound;
      end else if (used >= chm_pkg::Capacity) begin
        r.status = chm_pkg::StFull;
      end else begin
        e = used;
        ent_key_high[e] = kh;
        ent_key_low[e] = kl;
        ent_value[e] = v;
        ent_next[e] = 0;
        if (last == 0) bucket_head[b] = e + 1;
        else ent_next[last-1] = e + 1;
        used = e + 1;
        r.status = chm_pkg::StInserted;
      end
      pending_rsp.push_back(r);
    endfunction

    function void check_response(logic [1:0] st, logic [chm_pkg::ValW-1:0] v);
      lookup_rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response status=%0d value=%0h", st, v);
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (st !== exp_rsp.status || v !== exp_rsp.value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response mismatch: expected status=%0d value=%0h, got status=%0d value=%0h",
                   exp_rsp.status, exp_rsp.value, st, v);
      end
    endfunction
  endclass
endpackage

/* bench/testbench.sv */
// Top-level bench for chained_hash_map_128bit_key: drives sets and gets over
// the request channel with random idling and checks every response against
// the scoreboard in chm_tb_pkg. Depends on chm_pkg, chm_if and the RTL.
`timescale 1ns / 1ps
module testbench;
  localparam int unsigned StallLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  chm_req_if req ();
  chm_rsp_if rsp ();

  chained_hash_map_128bit_key dut (.clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp));

  always #10 clk_i = ~clk_i;

  chm_tb_pkg::hash_map_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int unsigned idle_cycles = 0;
  bit timed_out = 1'b0;

  logic [chm_pkg::KeyW-1:0] used_high[$];
  logic [chm_pkg::KeyW-1:0] used_low[$];

  initial begin
    req.valid = 1'b0;
    req.action = chm_pkg::ActSet;
    req.key_high = '0;
    req.key_low = '0;
    req.value_in = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req.valid && req.ready)
        sb.note_request(req.action, req.key_high, req.key_low, req.value_in);
      if (rsp.valid && rsp.ready) sb.check_response(rsp.status, rsp.value_out);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [chm_pkg::KeyW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_word(logic act, logic [chm_pkg::KeyW-1:0] kh,
                           logic [chm_pkg::KeyW-1:0] kl,
                           logic [chm_pkg::ValW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.key_high <= kh;
    req.key_low <= kl;
    req.value_in <= v;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    if (act == chm_pkg::ActSet) begin
      used_high.push_back(kh);
      used_low.push_back(kl);
    end
  endtask

  task automatic send_random(int unsigned n);
    int unsigned k, r;
    logic [chm_pkg::KeyW-1:0] kh, kl;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (used_high.size() != 0 && r < 55) begin
        k = $urandom_range(used_high.size() - 1);
        kh = used_high[k];
        kl = used_low[k];
      end else if (r < 65) begin
        // crowd a few buckets: small key_high, key_low a multiple of N
        kh = 64'($urandom_range(3));
        kl = 64'($urandom_range(20)) * 64'(chm_pkg::NumBuckets);
      end else begin
        kh = rand64();
        kl = rand64();
      end
      send_word($urandom_range(1) ? chm_pkg::ActGet : chm_pkg::ActSet, kh, kl,
                chm_pkg::ValW'($urandom()));
    end
  endtask

  task automatic drain();
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, colliding keys, update, miss
    send_word(chm_pkg::ActGet, '0, '0, '0);
    send_word(chm_pkg::ActSet, '0, '0, '1);
    send_word(chm_pkg::ActGet, '0, '0, '0);
    send_word(chm_pkg::ActSet, '1, '1, 24'h000000);
    send_word(chm_pkg::ActGet, '1, '1, '1);
    send_word(chm_pkg::ActSet, '0, 64'(chm_pkg::NumBuckets), 24'h123456);
    send_word(chm_pkg::ActSet, '0, 64'(2 * chm_pkg::NumBuckets), 24'hABCDEF);
    send_word(chm_pkg::ActSet, 64'd1, 64'd0, 24'h555555);
    send_word(chm_pkg::ActGet, '0, 64'(2 * chm_pkg::NumBuckets), '0);
    send_word(chm_pkg::ActGet, '0, 64'(3 * chm_pkg::NumBuckets), '0);
    send_word(chm_pkg::ActSet, '0, 64'(chm_pkg::NumBuckets), 24'hAAAAAA);
    send_word(chm_pkg::ActGet, '0, 64'(chm_pkg::NumBuckets), '0);
    send_word(chm_pkg::ActGet, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, '0);
    send_word(chm_pkg::ActSet, 64'hAAAA_AAAA_AAAA_AAAA, 64'h8000_0000_0000_0000,
              24'h800000);
    send_word(chm_pkg::ActGet, 64'hAAAA_AAAA_AAAA_AAAA, 64'h8000_0000_0000_0000, '0);
    req.valid <= 1'b0;
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(410);
    send_idle_pct = 47; recv_stall_pct = 0;  send_random(410);
    send_idle_pct = 0;  recv_stall_pct = 47; send_random(410);
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_random(50);
    join
    send_idle_pct = 15; recv_stall_pct = 15; send_random(410);
    req.valid <= 1'b0;
    drain();

    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
